### sv/mee_pkg.sv
package mee_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int DATA_W        = 32;
  localparam int CNT_W         = 11;
  localparam int ESC_W         = 31;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CNT_W-1:0] LIMIT_MAX  = 11'd1024;
  localparam logic [CNT_W-1:0] ITER_RESET = 11'd256;
  localparam logic [ESC_W-1:0] ESC_RESET  = 31'd1677721600;

  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_LIMIT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_XX,
    ST_MUL_YY,
    ST_MUL_XY,
    ST_CHECK
  } state_e;

endpackage

### sv/mandelbrot_escape_time_core.sv
// Each check steps MUL_XX, MUL_YY, MUL_XY, CHECK; one shared 32x32 multiplier used thrice.
// A point that stops with count N makes N+1 magnitude checks, or N when N is the limit.
// The result strobe appears in the cycle after the last check; a zero limit gives it in the
// cycle after the start, and the next start is taken in the cycle of the strobe.
// One point at a time: a start is taken only while idle, and the receiver cannot stall.
// Reset: asynchronous, active low; restores iteration_limit 256 and escape_limit 100.0.
module mandelbrot_escape_time_core #(
  parameter int FRAC_BITS = mee_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [mee_pkg::DATA_W-1:0]  point_re_i,
  input  logic signed [mee_pkg::DATA_W-1:0]  point_im_i,
  input  logic                               cfg_we_i,
  input  logic [mee_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mee_pkg::ESC_W-1:0]          cfg_wdata_i,
  output logic                               result_valid_o,
  output logic [mee_pkg::CNT_W-1:0]          iteration_count_o
);

  localparam int DW = mee_pkg::DATA_W;
  localparam int PW = 2 * DW;
  localparam int SW = PW - FRAC_BITS;
  localparam int UW = SW + 2;

  mee_pkg::state_e state_q, state_d;

  logic [mee_pkg::CNT_W-1:0] iter_limit_q;
  logic [mee_pkg::ESC_W-1:0] esc_limit_q;
  logic [mee_pkg::CNT_W-1:0] lim_eff;
  logic [mee_pkg::CNT_W-1:0] cnt_q;
  logic [mee_pkg::CNT_W-1:0] cnt_inc;
  logic [mee_pkg::CNT_W-1:0] result_q;
  logic                      valid_q;

  logic signed [DW-1:0] x_q, y_q, re_q, im_q;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_d, prod_q;
  logic signed [SW-1:0] prod_sh;
  logic signed [SW-1:0] x2_q, y2_q;
  logic signed [SW:0]   mag;
  logic signed [SW:0]   esc_ext;
  logic signed [UW-1:0] nx_full, ny_full;
  logic signed [DW-1:0] nx_sat, ny_sat;

  logic accept;
  logic escape;
  logic last_iter;

  assign accept    = start && (state_q == mee_pkg::ST_IDLE);
  assign lim_eff   = (iter_limit_q > mee_pkg::LIMIT_MAX) ? mee_pkg::LIMIT_MAX : iter_limit_q;
  assign cnt_inc   = cnt_q + 1'b1;

  assign prod_d  = mul_a * mul_b;
  assign prod_sh = $signed(prod_q[PW-1:FRAC_BITS]);

  assign mag     = {x2_q[SW-1], x2_q} + {y2_q[SW-1], y2_q};
  assign esc_ext = $signed({{(SW + 1 - mee_pkg::ESC_W){1'b0}}, esc_limit_q});
  assign escape  = mag > esc_ext;
  assign last_iter = (cnt_inc == lim_eff);

  assign nx_full = {{2{x2_q[SW-1]}}, x2_q} - {{2{y2_q[SW-1]}}, y2_q}
                 + {{(UW-DW){re_q[DW-1]}}, re_q};
  assign ny_full = {prod_sh[SW-1], prod_sh, 1'b0} + {{(UW-DW){im_q[DW-1]}}, im_q};

  always_comb begin
    if ((&nx_full[UW-1:DW-1]) || !(|nx_full[UW-1:DW-1])) begin
      nx_sat = nx_full[DW-1:0];
    end else begin
      nx_sat = nx_full[UW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    if ((&ny_full[UW-1:DW-1]) || !(|ny_full[UW-1:DW-1])) begin
      ny_sat = ny_full[DW-1:0];
    end else begin
      ny_sat = ny_full[UW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mee_pkg::ST_IDLE: begin
        if (start && (lim_eff != '0)) begin
          state_d = mee_pkg::ST_MUL_XX;
        end
      end
      mee_pkg::ST_MUL_XX: state_d = mee_pkg::ST_MUL_YY;
      mee_pkg::ST_MUL_YY: state_d = mee_pkg::ST_MUL_XY;
      mee_pkg::ST_MUL_XY: state_d = mee_pkg::ST_CHECK;
      mee_pkg::ST_CHECK: begin
        if (escape || last_iter) begin
          state_d = mee_pkg::ST_IDLE;
        end else begin
          state_d = mee_pkg::ST_MUL_XX;
        end
      end
      default: state_d = mee_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b1;
    mul_a = x_q;
    mul_b = x_q;
    case (state_q)
      mee_pkg::ST_IDLE:   busy = 1'b0;
      mee_pkg::ST_MUL_XX: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      mee_pkg::ST_MUL_YY: begin
        mul_a = y_q;
        mul_b = y_q;
      end
      mee_pkg::ST_MUL_XY: begin
        mul_a = x_q;
        mul_b = y_q;
      end
      mee_pkg::ST_CHECK:  busy = 1'b1;
      default:            busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mee_pkg::ST_IDLE;
      valid_q      <= 1'b0;
      iter_limit_q <= mee_pkg::ITER_RESET;
      esc_limit_q  <= mee_pkg::ESC_RESET;
    end else begin
      state_q <= state_d;
      valid_q <= (accept && (lim_eff == '0))
              || ((state_q == mee_pkg::ST_CHECK) && (escape || last_iter));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mee_pkg::CFG_ITER_LIMIT: iter_limit_q <= cfg_wdata_i[mee_pkg::CNT_W-1:0];
          mee_pkg::CFG_ESC_LIMIT:  esc_limit_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (accept) begin
      x_q    <= point_re_i;
      y_q    <= point_im_i;
      re_q   <= point_re_i;
      im_q   <= point_im_i;
      cnt_q  <= '0;
      if (lim_eff == '0) begin
        result_q <= '0;
      end
    end
    case (state_q)
      mee_pkg::ST_MUL_YY: x2_q <= prod_sh;
      mee_pkg::ST_MUL_XY: y2_q <= prod_sh;
      mee_pkg::ST_CHECK: begin
        if (escape) begin
          result_q <= cnt_q;
        end else begin
          cnt_q <= cnt_inc;
          x_q   <= nx_sat;
          y_q   <= ny_sat;
          if (last_iter) begin
            result_q <= cnt_inc;
          end
        end
      end
      default: ;
    endcase
  end

  assign result_valid_o    = valid_q;
  assign iteration_count_o = result_q;

endmodule

### sv/mee_checker.sv
module mee_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      result_valid_o,
  input logic [mee_pkg::CNT_W-1:0] iteration_count_o
);

  // A result is never shown while a transaction is still in progress.
  a_valid_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // Finishing a point always presents its result.
  a_fall_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy fell without a result");

  // An accepted point either starts work or returns its result at once.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || result_valid_o))
    else $error("accepted transaction was dropped");

  // A result comes only from work or an accepted point in the cycle before.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(busy) || $past(start)))
    else $error("result without a transaction");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (iteration_count_o <= mee_pkg::LIMIT_MAX))
    else $error("iteration count above the maximum limit");

endmodule

bind mandelbrot_escape_time_core mee_checker u_mee_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .result_valid_o    (result_valid_o),
  .iteration_count_o (iteration_count_o)
);
